// ===== design/setq_pkg.sv =====
// ---------------------------------------------------------------------------
// setq_pkg
// Shared types and codes for the sorted expiry timer queue.
// ---------------------------------------------------------------------------
package setq_pkg;

    localparam int ID_W   = 8;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 7;
    localparam int MAX_FIRE = 16;
    localparam int FIRE_W   = $clog2(MAX_FIRE);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_ADJUST = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_FIRED     = 3'd4;

    // classified command word passed from front to back
    typedef struct packed {
        logic [1:0]        cmd;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] tval;
    } op_t;

    // back end status seen by the top level
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             busy;
    } back_stat_t;

endpackage

// ===== design/setq_ifs.sv =====
// ---------------------------------------------------------------------------
// setq_ifs
// Command and result channels of the timer queue.
// ---------------------------------------------------------------------------
interface setq_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  timer_id;
    logic [31:0] expire_time;
    logic [31:0] now_time;

    modport source (output valid, command, timer_id, expire_time, now_time, input ready);
    modport sink   (input valid, command, timer_id, expire_time, now_time, output ready);
endinterface

interface setq_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] fired_id;
    logic       last;

    modport source (output valid, status, fired_id, last, input ready);
    modport sink   (input valid, status, fired_id, last, output ready);
endinterface

// ===== design/setq_front.sv =====
// ---------------------------------------------------------------------------
// setq_front
// Accepts command words, masks fields and queues them for the back end.
// ---------------------------------------------------------------------------
module setq_front #(
    parameter int ID_BITS   = 8,
    parameter int TIME_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    setq_cmd_if.sink       cmd_ch,
    output setq_pkg::op_t  q_op,
    output logic           q_valid,
    input  logic           q_pop
);
    import setq_pkg::*;

    localparam logic [ID_W-1:0] ID_MASK =
        (ID_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((64'd1 << ID_BITS) - 64'd1);
    localparam logic [TIME_W-1:0] TIME_MASK =
        (TIME_BITS >= TIME_W) ? {TIME_W{1'b1}} : TIME_W'((64'd1 << TIME_BITS) - 64'd1);

    op_t        buf_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    op_t        in_op;
    logic       push;

    // tick carries the current time, the others carry an expiry
    always_comb
    begin
        in_op.cmd  = cmd_ch.command;
        in_op.id   = cmd_ch.timer_id & ID_MASK;
        in_op.tval = ((cmd_ch.command == CMD_TICK) ? cmd_ch.now_time : cmd_ch.expire_time)
                     & TIME_MASK;
    end

    assign cmd_ch.ready = (cnt_reg != 2'd2);
    assign push         = cmd_ch.valid && cmd_ch.ready;
    assign q_valid      = (cnt_reg != 2'd0);
    assign q_op         = buf_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= in_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop && q_valid);
        end
    end

endmodule

// ===== design/setq_back.sv =====
// ---------------------------------------------------------------------------
// setq_back
// Sorted timer store and command sequencer with a result register.
// ---------------------------------------------------------------------------
module setq_back #(
    parameter int DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  setq_pkg::op_t        q_op,
    input  logic                 q_valid,
    output logic                 q_pop,
    setq_res_if.source           res_ch,
    output setq_pkg::back_stat_t stat
);
    import setq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMD  = 2'd1;
    localparam logic [1:0] S_ADJ  = 2'd2;
    localparam logic [1:0] S_TICK = 2'd3;

    logic [1:0]        state_reg, state_next;
    op_t               cur_reg, cur_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [FIRE_W-1:0] fire_reg, fire_next;
    logic [ID_W-1:0]   ids_reg [DEPTH];
    logic [TIME_W-1:0] exp_reg [DEPTH];
    logic [ID_W-1:0]   ids_next [DEPTH];
    logic [TIME_W-1:0] exp_next [DEPTH];

    logic              ovalid_reg;
    logic [2:0]        ostatus_reg;
    logic [ID_W-1:0]   oid_reg;
    logic              olast_reg;

    logic [DEPTH-1:0]  match, at_or_after, place_ge, drop_vec;
    logic              found, can_emit, do_place, do_drop, due, emit;
    logic [2:0]        e_status;
    logic [ID_W-1:0]   e_id;
    logic              e_last;

    assign can_emit = !ovalid_reg || res_ch.ready;

    // per slot: id match, insertion boundary, drop boundary
    always_comb
    begin
        logic pre;
        pre = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            match[i]    = (count_reg > CW'(i)) && (ids_reg[i] == cur_reg.id);
            place_ge[i] = (count_reg <= CW'(i)) || (cur_reg.tval <= exp_reg[i]);
            drop_vec[i] = (cur_reg.cmd == CMD_TICK) ? (i == 0) : match[i];
            pre         = pre | drop_vec[i];
            at_or_after[i] = pre;
        end
        found = |match;
        due   = (count_reg != '0) && (exp_reg[0] <= cur_reg.tval);
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        fire_next  = fire_reg;
        q_pop      = 1'b0;
        do_place   = 1'b0;
        do_drop    = 1'b0;
        emit       = 1'b0;
        e_status   = ST_DONE;
        e_id       = '0;
        e_last     = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_op;
                    fire_next  = '0;
                    state_next = (q_op.cmd == CMD_TICK) ? S_TICK : S_CMD;
                end
            end
            S_CMD:
            begin
                if (can_emit)
                begin
                    unique case (cur_reg.cmd)
                        CMD_INSERT:
                        begin
                            emit = 1'b1;
                            if (found)
                            begin
                                e_status = ST_DUPLICATE;
                            end
                            else if (count_reg >= CW'(DEPTH))
                            begin
                                e_status = ST_FULL;
                            end
                            else
                            begin
                                do_place = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                        CMD_REMOVE, CMD_ADJUST:
                        begin
                            if (!found)
                            begin
                                emit       = 1'b1;
                                e_status   = ST_NOT_FOUND;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                do_drop = 1'b1;
                                if (cur_reg.cmd == CMD_ADJUST)
                                begin
                                    state_next = S_ADJ;
                                end
                                else
                                begin
                                    emit       = 1'b1;
                                    state_next = S_IDLE;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADJ:
            begin
                if (can_emit)
                begin
                    do_place   = 1'b1;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (due)
                    begin
                        do_drop  = 1'b1;
                        e_status = ST_FIRED;
                        e_id     = ids_reg[0];
                        // last once the next head is not due or the pop budget is spent
                        e_last   = (count_reg == CW'(1)) || (exp_reg[1] > cur_reg.tval)
                                   || (fire_reg == FIRE_W'(MAX_FIRE - 1));
                        fire_next = fire_reg + FIRE_W'(1);
                    end
                    if (e_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // shift the store open for a place, closed for a drop
    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            ids_next[i] = ids_reg[i];
            exp_next[i] = exp_reg[i];
            if (do_place && place_ge[i])
            begin
                if (i == 0 || !place_ge[(i == 0) ? 0 : i - 1])
                begin
                    ids_next[i] = cur_reg.id;
                    exp_next[i] = cur_reg.tval;
                end
                else
                begin
                    ids_next[i] = ids_reg[(i == 0) ? 0 : i - 1];
                    exp_next[i] = exp_reg[(i == 0) ? 0 : i - 1];
                end
            end
            else if (do_drop && at_or_after[i] && i < DEPTH - 1)
            begin
                ids_next[i] = ids_reg[(i < DEPTH - 1) ? i + 1 : i];
                exp_next[i] = exp_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
        if (do_place)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_drop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        for (int i = 0; i < DEPTH; i++)
        begin
            ids_reg[i] <= ids_next[i];
            exp_reg[i] <= exp_next[i];
        end
        if (emit)
        begin
            ostatus_reg <= e_status;
            oid_reg     <= e_id;
            olast_reg   <= e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            fire_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            fire_reg  <= fire_next;
            if (emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (res_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign res_ch.valid    = ovalid_reg;
    assign res_ch.status   = ostatus_reg;
    assign res_ch.fired_id = oid_reg;
    assign res_ch.last     = olast_reg;

    assign stat.count = CNT_W'(count_reg);
    assign stat.busy  = (state_reg != S_IDLE);

endmodule

// ===== design/sorted_expiry_timer_queue.sv =====
// ---------------------------------------------------------------------------
// sorted_expiry_timer_queue
// Timer list kept sorted by expiry with insert, remove, adjust and tick.
// ---------------------------------------------------------------------------
//  channel   dir  payload                                    handshake
//  cmd_ch    in   command, timer_id, expire_time, now_time   valid/ready
//  res_ch    out  status, fired_id, last                     valid/ready
//
//  An accepted command goes through the command queue and the command
//  register before its word loads the result register; adjust drops,
//  then places. A tick loads one word per popped timer, one per cycle
//  while the result register is free, or a done word if nothing is due.
//  The sequencer updates the whole store in one shift per cycle. A
//  two-word command queue keeps accepting while the back end works. A
//  stalled result register holds the sequencer; reset empties the list.
// ---------------------------------------------------------------------------
module sorted_expiry_timer_queue #(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 8,
    parameter int TIME_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    setq_cmd_if.sink   cmd_ch,
    setq_res_if.source res_ch
);
    import setq_pkg::*;

    op_t        q_op;
    logic       q_valid;
    logic       q_pop;
    back_stat_t stat;

    setq_front #(
        .ID_BITS   (ID_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_ch  (cmd_ch),
        .q_op    (q_op),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    setq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_op    (q_op),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .res_ch  (res_ch),
        .stat    (stat)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= CNT_W'(DEPTH))
        else $error("timer count beyond depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.count == $past(stat.count)) || (stat.count == $past(stat.count) + CNT_W'(1))
        || (stat.count + CNT_W'(1) == $past(stat.count)))
        else $error("timer count moved by more than one");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && res_ch.status != ST_FIRED) |-> res_ch.last)
        else $error("non-fired result without last");

    a_idle_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!stat.busy && q_valid))
        else $error("queue popped while busy");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives insert, remove, adjust and tick words into the timer queue, keeps a
// sorted shadow list to predict every result word and checks each field.
// ---------------------------------------------------------------------------
module tb_top;
    import setq_pkg::*;

    localparam int DEPTH = 16;

    logic clk;
    logic rst_n;

    setq_cmd_if cmd_ch ();
    setq_res_if res_ch ();

    sorted_expiry_timer_queue #(.DEPTH(DEPTH)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch.sink),
        .res_ch (res_ch.source)
    );

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] fired_id;
        logic       last;
    } res_word_t;

    // shadow timer list, slot 0 earliest
    logic [7:0]  shadow_id[$];
    logic [31:0] shadow_exp[$];
    res_word_t   pending_res[$];
    int          fail_count;
    int          burst_left;
    int          stall_mode;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = 1'b1;
            #2 clk = 1'b0;
        end
    end

    function automatic int find_timer(input logic [7:0] id);
        for (int i = 0; i < shadow_id.size(); i++)
            if (shadow_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void place_timer(input logic [7:0] id, input logic [31:0] ex);
        int pos;
        pos = 0;
        while (pos < shadow_id.size() && ex > shadow_exp[pos])
            pos++;
        shadow_id.insert(pos, id);
        shadow_exp.insert(pos, ex);
    endfunction

    function automatic void push_res(input logic [2:0] st, input logic [7:0] id,
                                     input logic lst);
        res_word_t w;
        w.status   = st;
        w.fired_id = id;
        w.last     = lst;
        pending_res.push_back(w);
    endfunction

    function automatic void predict_queue(input logic [1:0] cmd, input logic [7:0] id,
                                          input logic [31:0] ex, input logic [31:0] now);
        int pos;
        int n;
        case (cmd)
            CMD_INSERT:
            begin
                if (find_timer(id) >= 0)
                    push_res(ST_DUPLICATE, 8'd0, 1'b1);
                else if (shadow_id.size() >= DEPTH)
                    push_res(ST_FULL, 8'd0, 1'b1);
                else
                begin
                    place_timer(id, ex);
                    push_res(ST_DONE, 8'd0, 1'b1);
                end
            end
            CMD_REMOVE, CMD_ADJUST:
            begin
                pos = find_timer(id);
                if (pos < 0)
                    push_res(ST_NOT_FOUND, 8'd0, 1'b1);
                else
                begin
                    shadow_id.delete(pos);
                    shadow_exp.delete(pos);
                    if (cmd == CMD_ADJUST)
                        place_timer(id, ex);
                    push_res(ST_DONE, 8'd0, 1'b1);
                end
            end
            default:
            begin
                n = 0;
                while (n < MAX_FIRE && shadow_id.size() > 0 && shadow_exp[0] <= now)
                begin
                    push_res(ST_FIRED, shadow_id[0], 1'b0);
                    void'(shadow_id.pop_front());
                    void'(shadow_exp.pop_front());
                    n++;
                end
                if (n == 0)
                    push_res(ST_DONE, 8'd0, 1'b1);
                else
                    pending_res[pending_res.size() - 1].last = 1'b1;
            end
        endcase
    endfunction

    // send one command word, with bursty gaps ahead of it
    task automatic send_word(input logic [1:0] cmd, input logic [7:0] id,
                             input logic [31:0] ex, input logic [31:0] now);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        cmd_ch.valid       <= 1'b1;
        cmd_ch.command     <= cmd;
        cmd_ch.timer_id    <= id;
        cmd_ch.expire_time <= ex;
        cmd_ch.now_time    <= now;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        predict_queue(cmd, id, ex, now);
    endtask

    // result checker; receiver stalls on its own pattern
    always @(posedge clk)
    begin
        res_word_t exp_w;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_res.size() == 0)
            begin
                $display("%0t: unexpected result word status=%0d id=%0d last=%0d",
                         $time, res_ch.status, res_ch.fired_id, res_ch.last);
                fail_count++;
            end
            else
            begin
                exp_w = pending_res.pop_front();
                if (res_ch.status !== exp_w.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_w.status, res_ch.status);
                    fail_count++;
                end
                if (res_ch.fired_id !== exp_w.fired_id)
                begin
                    $display("%0t: fired_id expected %0d actual %0d",
                             $time, exp_w.fired_id, res_ch.fired_id);
                    fail_count++;
                end
                if (res_ch.last !== exp_w.last)
                begin
                    $display("%0t: last expected %0d actual %0d",
                             $time, exp_w.last, res_ch.last);
                    fail_count++;
                end
            end
        end
        case (stall_mode)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= ($urandom_range(0, 3) != 0);
            default: res_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
        if ($urandom_range(0, 99) == 0)
            stall_mode <= $urandom_range(0, 2);
    end

    function automatic logic [31:0] rand_time();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 40);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 40);
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        send_word(CMD_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);      // tick on empty list
        send_word(CMD_REMOVE, 8'd5, 32'd0, 32'd0);            // unknown id
        send_word(CMD_ADJUST, 8'hFF, 32'd9, 32'd0);           // unknown id
        send_word(CMD_INSERT, 8'h00, 32'd100, 32'd0);
        send_word(CMD_INSERT, 8'hFF, 32'hFFFF_FFFF, 32'd0);
        send_word(CMD_INSERT, 8'h55, 32'd100, 32'd0);         // equal expiry goes ahead
        send_word(CMD_INSERT, 8'h55, 32'd7, 32'd0);           // duplicate
        send_word(CMD_INSERT, 8'hAA, 32'd0, 32'd0);
        send_word(CMD_ADJUST, 8'hAA, 32'd100, 32'd0);         // equal expiry on adjust
        send_word(CMD_TICK, 8'd0, 32'd0, 32'd99);             // nothing due
        send_word(CMD_TICK, 8'd0, 32'd0, 32'd100);
        send_word(CMD_REMOVE, 8'hFF, 32'd0, 32'd0);
        for (int i = 0; i < DEPTH; i++)
            send_word(CMD_INSERT, 8'(i + 16), 32'(i * 3), 32'd0);
        send_word(CMD_INSERT, 8'h10, 32'd1, 32'd0);           // duplicate when full
        send_word(CMD_INSERT, 8'hEE, 32'd1, 32'd0);           // full
        send_word(CMD_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);      // pop the lot
    endtask

    task automatic test_random(input int count);
        logic [1:0]  cmd;
        logic [7:0]  id;
        int          pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                cmd = CMD_INSERT;
            else if (pick < 55)
                cmd = CMD_REMOVE;
            else if (pick < 75)
                cmd = CMD_ADJUST;
            else
                cmd = CMD_TICK;
            // mostly hit stored ids so remove and adjust reach the list
            if (cmd != CMD_INSERT && shadow_id.size() > 0 && $urandom_range(0, 3) != 0)
                id = shadow_id[$urandom_range(0, shadow_id.size() - 1)];
            else
                id = 8'($urandom());
            send_word(cmd, id, rand_time(), rand_time());
        end
    endtask

    initial
    begin
        int guard;
        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.command     = CMD_TICK;
        cmd_ch.timer_id    = '0;
        cmd_ch.expire_time = '0;
        cmd_ch.now_time    = '0;
        res_ch.ready       = 1'b0;
        fail_count         = 0;
        burst_left         = 0;
        stall_mode         = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(390);
        cmd_ch.valid <= 1'b0;
        guard = 0;
        while (pending_res.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_res.size() == 0)
            $display("sorted_expiry_timer_queue regression: pass");
        else
            $display("sorted_expiry_timer_queue regression: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("sorted_expiry_timer_queue regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/setq_pkg.sv
design/setq_ifs.sv
design/setq_front.sv
design/setq_back.sv
design/sorted_expiry_timer_queue.sv
tb/tb_top.sv
